FILE: sv/assert_macros.svh
// Assertion macros for the port-level checker.
// Each macro expands to one labeled concurrent assertion on a clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, clocked and disabled while reset is low
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Valid that is not taken stays up in the next cycle
`define ASSERT_HOLD(lbl, clk, rst_n, vld, rdy) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy) |=> (vld))) \
        else $error("valid dropped without a transfer");

`endif

FILE: sv/me_pkg.sv
// Shared widths, types and command/status structs for the modular exponentiation block.
// No dependencies; the design files refer to this package by scoped names, the testbench imports it.
package me_pkg;

    localparam int MOD_WIDTH = 32;
    localparam int EXP_WIDTH = 32;

    localparam int BASE_W   = 63;
    localparam int EXP_IN_W = 32;
    localparam int RES_W    = 32;
    localparam int CFG_W    = 32;

    // dividend width: holds the raw base and any product of two residues
    localparam int DIV_W  = 64;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam int BCNT_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

    typedef logic [MOD_WIDTH-1:0] t_mod;
    typedef logic [EXP_WIDTH-1:0] t_exp;
    typedef logic [DIV_W-1:0]     t_dvd;
    typedef logic [DCNT_W-1:0]    t_dcnt;
    typedef logic [BCNT_W-1:0]    t_bcnt;
    typedef logic [BASE_W-1:0]    t_base;
    typedef logic [EXP_IN_W-1:0]  t_exp_in;
    typedef logic [RES_W-1:0]     t_res;
    typedef logic [CFG_W-1:0]     t_cfg;

    localparam t_mod  MOD_RESET = t_mod'(32'd10007);
    localparam t_dcnt DCNT_LAST = t_dcnt'(DIV_W - 1);
    localparam t_bcnt BCNT_LAST = t_bcnt'(EXP_WIDTH - 1);

    typedef struct packed {
        logic load;       // capture base and exponent, start base reduction
        logic init_acc;   // accumulator to one
        logic ld_sq;      // dividend from acc * acc
        logic ld_mul;     // dividend from acc * base
        logic div_step;   // one restoring remainder step
        logic wr_base;    // reduced value into base
        logic wr_acc;     // reduced value into accumulator
        logic shift_exp;  // advance to next exponent bit
        logic wr_out;     // accumulator into result register
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_msb;
        logic mod_zero;
    } t_dp_sts;

endpackage

FILE: sv/me_ifs.sv
// Valid/ready channel interfaces for input items, results and the modulus write port.
// Depends on me_pkg for payload types.
interface me_in_if;
    logic             valid;
    logic             ready;
    me_pkg::t_base    base_value;
    me_pkg::t_exp_in  exponent;
    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface me_out_if;
    logic          valid;
    logic          ready;
    me_pkg::t_res  power_result;
    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

interface me_cfg_if;
    logic          valid;
    logic          ready;
    me_pkg::t_cfg  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/me_ctrl.sv
// Sequencer for square-and-multiply: steps the datapath through base reduction,
// per-bit square and multiply, and result hand-off. Depends on me_pkg.
module me_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  me_pkg::t_dp_sts i_sts,
    output me_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_BDIV, S_BWR, S_SQ, S_SQDIV, S_SQWR,
        S_ML, S_MLDIV, S_MLWR, S_NEXT, S_DONE
    } t_state;

    t_state         r_state, n_state;
    me_pkg::t_dcnt  r_dcnt, n_dcnt;
    me_pkg::t_bcnt  r_bcnt, n_bcnt;
    logic           r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_dcnt      = r_dcnt;
        n_bcnt      = r_bcnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        // drop valid once the pending result is transferred
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_dcnt     = '0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.init_acc = 1'b1;
                if (i_sts.exp_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.mod_zero) begin
                    n_state = S_BWR;
                end else begin
                    n_state = S_BDIV;
                end
            end
            S_BDIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + 1'b1;
                if (r_dcnt == me_pkg::DCNT_LAST) begin
                    n_state = S_BWR;
                end
            end
            S_BWR: begin
                o_cmd.wr_base = 1'b1;
                n_bcnt        = '0;
                n_state       = S_SQ;
            end
            S_SQ: begin
                o_cmd.ld_sq = 1'b1;
                n_dcnt      = '0;
                n_state     = i_sts.mod_zero ? S_SQWR : S_SQDIV;
            end
            S_SQDIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + 1'b1;
                if (r_dcnt == me_pkg::DCNT_LAST) begin
                    n_state = S_SQWR;
                end
            end
            S_SQWR: begin
                o_cmd.wr_acc = 1'b1;
                n_state      = i_sts.exp_msb ? S_ML : S_NEXT;
            end
            S_ML: begin
                o_cmd.ld_mul = 1'b1;
                n_dcnt       = '0;
                n_state      = i_sts.mod_zero ? S_MLWR : S_MLDIV;
            end
            S_MLDIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + 1'b1;
                if (r_dcnt == me_pkg::DCNT_LAST) begin
                    n_state = S_MLWR;
                end
            end
            S_MLWR: begin
                o_cmd.wr_acc = 1'b1;
                n_state      = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.shift_exp = 1'b1;
                if (r_bcnt == me_pkg::BCNT_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_bcnt  = r_bcnt + 1'b1;
                    n_state = S_SQ;
                end
            end
            S_DONE: begin
                // hold until the output register is free or being transferred
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.wr_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dcnt      <= '0;
            r_bcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dcnt      <= n_dcnt;
            r_bcnt      <= n_bcnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/me_dp.sv
// Datapath: modulus register, operand registers, one multiplier and a
// bit-serial restoring remainder unit. Depends on me_pkg.
module me_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  me_pkg::t_dp_cmd i_cmd,
    output me_pkg::t_dp_sts o_sts,
    input  me_pkg::t_base   i_base,
    input  me_pkg::t_exp_in i_exponent,
    input  logic            i_cfg_we,
    input  me_pkg::t_cfg    i_cfg_data,
    output me_pkg::t_res    o_power_result
);

    me_pkg::t_mod  r_mod;
    me_pkg::t_mod  r_base;
    me_pkg::t_mod  r_acc;
    me_pkg::t_mod  r_rem;
    me_pkg::t_exp  r_exp;
    me_pkg::t_dvd  r_dvd;
    me_pkg::t_res  r_res;

    me_pkg::t_mod                     mul_b;
    logic [2*me_pkg::MOD_WIDTH-1:0]   prod;
    logic [me_pkg::MOD_WIDTH:0]       trial;
    logic [me_pkg::MOD_WIDTH:0]       diff;
    me_pkg::t_mod                     n_rem;
    me_pkg::t_mod                     reduced;
    logic                             mod_zero;

    assign mod_zero = (r_mod == '0);

    always_comb begin
        mul_b = i_cmd.ld_mul ? r_base : r_acc;
        prod  = r_acc * mul_b;
        // shift in the next dividend bit, subtract when it fits
        trial = {r_rem, r_dvd[me_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_mod};
        if (trial >= {1'b0, r_mod}) begin
            n_rem = diff[me_pkg::MOD_WIDTH-1:0];
        end else begin
            n_rem = trial[me_pkg::MOD_WIDTH-1:0];
        end
        // a zero modulus wraps at the register width
        reduced = mod_zero ? r_dvd[me_pkg::MOD_WIDTH-1:0] : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= me_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            r_mod <= me_pkg::t_mod'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd <= me_pkg::t_dvd'(i_base);
        end else if (i_cmd.ld_sq || i_cmd.ld_mul) begin
            r_dvd <= me_pkg::t_dvd'(prod);
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
        end

        if (i_cmd.load || i_cmd.ld_sq || i_cmd.ld_mul) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end

        if (i_cmd.load) begin
            r_exp <= me_pkg::t_exp'(i_exponent);
        end else if (i_cmd.shift_exp) begin
            r_exp <= r_exp << 1;
        end

        if (i_cmd.init_acc) begin
            r_acc <= me_pkg::t_mod'(1);
        end else if (i_cmd.wr_acc) begin
            r_acc <= reduced;
        end

        if (i_cmd.wr_base) begin
            r_base <= reduced;
        end

        if (i_cmd.wr_out) begin
            r_res <= me_pkg::t_res'(r_acc);
        end
    end

    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_msb  = r_exp[me_pkg::EXP_WIDTH-1];
    assign o_sts.mod_zero = mod_zero;
    assign o_power_result = r_res;

endmodule

FILE: sv/modular_exponentiation.sv
// Run time is set by the 64-step bit-serial remainder unit, which reduces the base once
// and every square and multiply product; a zero exponent skips all of them, and a zero
// modulus skips the remainder steps.
// Throughput: one item at a time; the next input is taken once the result is in the
// output register. Synchronous active-low reset clears control; modulus resets to 10007.
module modular_exponentiation (
    input  logic       i_clk,
    input  logic       i_rst_n,
    me_in_if.sink      i_in,
    me_out_if.source   o_out,
    me_cfg_if.sink     i_cfg
);

    me_pkg::t_dp_cmd cmd;
    me_pkg::t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    me_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    me_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_base         (i_in.base_value),
        .i_exponent     (i_in.exponent),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .o_power_result (o_out.power_result)
    );

endmodule

FILE: sv/me_chk.sv
// Port-level checker for modular_exponentiation, attached by bind.
// Depends on assert_macros.svh and me_pkg.
`include "assert_macros.svh"

module me_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input me_pkg::t_res  i_out_result
);

    `ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, i_out_valid, i_out_ready)
    `ASSERT_PROP(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_result))
    // an accepted item keeps the input closed for at least the next cycle
    `ASSERT_PROP(a_busy_after_in, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    // a new result is posted as the block turns idle
    `ASSERT_PROP(a_idle_on_result, i_clk, i_rst_n, $rose(i_out_valid) |-> i_in_ready)

endmodule

bind modular_exponentiation me_chk u_me_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.power_result)
);

FILE: tb/sv/power_check_pkg.sv
// Scoreboard for the modular exponentiation block: predicts base^exponent mod modulus
// and compares each result transfer against the oldest prediction. Depends on me_pkg.
package power_check_pkg;
    import me_pkg::*;

    class power_scoreboard;
        t_mod modulus;
        t_res pending_powers[$];
        int   mismatches;

        function new();
            modulus    = MOD_RESET;
            mismatches = 0;
        endfunction

        function void set_modulus(t_cfg value);
            modulus = t_mod'(value);
        endfunction

        // A zero modulus stands for 2^MOD_WIDTH: wrap at the register width
        function bit [63:0] mod_reduce(bit [63:0] x);
            if (modulus == '0) begin
                return x & ((64'd1 << MOD_WIDTH) - 64'd1);
            end
            return x % 64'(modulus);
        endfunction

        function t_res predict_power(t_base base_value, t_exp_in exponent);
            bit [63:0] reduced_base;
            bit [63:0] accum;
            t_exp      e;
            reduced_base = mod_reduce(64'(base_value));
            e            = t_exp'(exponent);
            // zero exponent gives one, even under a modulus of one
            if (e == '0) begin
                return t_res'(1);
            end
            accum = 64'd1;
            for (int i = EXP_WIDTH - 1; i >= 0; i--) begin
                accum = mod_reduce(accum * accum);
                if (e[i]) begin
                    accum = mod_reduce(accum * reduced_base);
                end
            end
            return t_res'(accum);
        endfunction

        function void note_input(t_base base_value, t_exp_in exponent);
            pending_powers.push_back(predict_power(base_value, exponent));
        endfunction

        function void check_result(t_res actual);
            t_res expected;
            if (pending_powers.size() == 0) begin
                $error("power_result: expected none, actual %0d", actual);
                mismatches++;
                return;
            end
            expected = pending_powers.pop_front();
            if (actual !== expected) begin
                $error("power_result: expected %0d, actual %0d", expected, actual);
                mismatches++;
            end
        endfunction

        function int pending_count();
            return pending_powers.size();
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_top.sv
// Top-level testbench for modular_exponentiation: directed and random items under
// several moduli, random stalls on both channels. Depends on me_pkg, me_ifs, power_check_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import me_pkg::*;
    import power_check_pkg::*;

    localparam int ITEMS_PER_PHASE = 72;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_CYCLES     = 12000;
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int TAIL_CYCLES     = 50;
    localparam int HOLD_AFTER      = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    me_in_if  in_ch();
    me_out_if out_ch();
    me_cfg_if cfg_ch();

    power_scoreboard sb;
    bit tail_quiet = 1'b0;
    int results_taken = 0;
    int stall_cycles = 0;

    modular_exponentiation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // Offer one item, possibly after a random gap; return at the accepting edge
    task automatic send_item(input t_base base_value, input t_exp_in exponent);
        if (!tail_quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.base_value <= base_value;
        in_ch.exponent   <= exponent;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid and hold until every expected result has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(input t_cfg value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_base random_base(t_mod m);
        int unsigned sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0: return t_base'({$urandom, $urandom});
            1: return t_base'($urandom_range(0, 15));
            // near a multiple of the modulus
            2: return t_base'(m) * t_base'($urandom_range(1, 3)) + t_base'($urandom_range(0, 1));
            default: return t_base'($urandom);
        endcase
    endfunction

    function automatic t_exp_in random_exponent();
        int unsigned sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: return t_exp_in'($urandom_range(0, 20));
            1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return t_exp_in'($urandom);
        endcase
    endfunction

    // Transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.power_result);
                results_taken <= results_taken + 1;
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.base_value, in_ch.exponent);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.set_modulus(cfg_ch.data);
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Result side: random back-pressure, one long hold-off to fill the block
    initial begin : result_sink
        bit held_off;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            if (!held_off && results_taken >= HOLD_AFTER) begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!tail_quiet && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_cfg phase_mods[NUM_PHASES];
        sb = new();
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.base_value <= '0;
        in_ch.exponent   <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus
        send_item('0, '0);
        send_item('0, t_exp_in'(5));
        send_item('1, '1);
        send_item(t_base'(1), '1);
        send_item('1, t_exp_in'(1));
        send_item(t_base'(10007), t_exp_in'(3));
        send_item(t_base'(10006), t_exp_in'(2));
        send_item(t_base'(64'h5555_5555_5555_5555), 32'h8000_0000);
        send_item(t_base'(64'h2AAA_AAAA_AAAA_AAAA), 32'h5555_5555);
        send_item(t_base'(12345), 32'hAAAA_AAAA);
        drain();

        // modulus of one
        write_modulus(t_cfg'(1));
        send_item(t_base'(5), '0);
        send_item(t_base'(5), t_exp_in'(7));
        send_item('1, '1);
        drain();

        // zero modulus wraps at the register width
        write_modulus('0);
        send_item('1, t_exp_in'(2));
        send_item(t_base'(3), '1);
        send_item('0, '0);
        send_item(t_base'(32'hFFFF_FFFF), t_exp_in'(3));
        drain();

        write_modulus('1);
        send_item('1, '1);
        send_item(t_base'(32'hFFFF_FFFE), t_exp_in'(2));
        send_item(t_base'(32'hFFFF_FFFF), t_exp_in'(5));

        phase_mods[0] = 32'hFFFF_FFFF;
        phase_mods[1] = t_cfg'(2);
        phase_mods[2] = t_cfg'($urandom);
        phase_mods[3] = t_cfg'(1);
        phase_mods[4] = '0;
        phase_mods[5] = 32'hFFFF_FFFB;
        phase_mods[6] = t_cfg'($urandom_range(3, 1000));
        phase_mods[7] = t_cfg'($urandom) | 32'h8000_0000;

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p == NUM_PHASES - 1) begin
                tail_quiet = 1'b1;
            end
            write_modulus(phase_mods[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_item(random_base(t_mod'(phase_mods[p])), random_exponent());
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
